// File: hdl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, codes and date arithmetic for the calendar day stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned WdayW  = 3;

  localparam logic [YearW-1:0]  YearMin    = YearW'(1);
  localparam logic [YearW-1:0]  YearMax    = YearW'(9999);
  localparam logic [MonthW-1:0] MonthFirst = MonthW'(1);
  localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);
  localparam logic [DayW-1:0]   DayFirst   = DayW'(1);
  localparam logic [DayW-1:0]   DayLast    = DayW'(31);

  localparam logic [YearW-1:0]  ResetYear  = YearW'(2021);
  localparam logic [MonthW-1:0] ResetMonth = MonthW'(1);
  localparam logic [DayW-1:0]   ResetDay   = DayW'(1);

  // ceil(2^20 / 100); exact quotient for every 14-bit year
  localparam logic [YearW-1:0]  Recip100   = YearW'(10486);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2,
    OP_NONE = 2'd3
  } cds_op_e;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    cds_op_e           op;
  } cds_item_t;

  typedef struct packed {
    logic              rejected;
    logic              leap;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } cds_date_t;

  function automatic logic [7:0] div100(input logic [YearW-1:0] y);
    logic [2*YearW-1:0] p;
    p = (2*YearW)'(y) * (2*YearW)'(Recip100);
    return p[2*YearW-1:20];
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [7:0]       q;
    logic [YearW-1:0] hund;
    q    = div100(y);
    hund = YearW'(q) * YearW'(100);
    return (y[1:0] == 2'b00) && ((y != hund) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                     len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:  len = DayW'(30);
      default:                  len = DayW'(31);
    endcase
    return len;
  endfunction

  // 2m + floor(3(m+1)/5) for months 3..14
  function automatic logic [5:0] month_term(input logic [MonthW-1:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd8;
      4'd4:    t = 6'd11;
      4'd5:    t = 6'd13;
      4'd6:    t = 6'd16;
      4'd7:    t = 6'd18;
      4'd8:    t = 6'd21;
      4'd9:    t = 6'd24;
      4'd10:   t = 6'd26;
      4'd11:   t = 6'd29;
      4'd12:   t = 6'd31;
      4'd13:   t = 6'd34;
      4'd14:   t = 6'd37;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // 8 is 1 mod 7: fold octal digits
  function automatic logic [WdayW-1:0] mod7(input logic [14:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[WdayW-1:0];
  endfunction

  function automatic logic [WdayW-1:0] weekday(input logic [YearW-1:0] y,
                                               input logic [MonthW-1:0] m,
                                               input logic [DayW-1:0] d);
    logic [YearW-1:0]  ya;
    logic [MonthW-1:0] ma;
    logic [7:0]        q;
    logic [14:0]       s;
    if (m < 4'd3) begin
      ya = y - YearW'(1);
      ma = m + MonthW'(12);
    end else begin
      ya = y;
      ma = m;
    end
    q = div100(ya);
    s = 15'(d) + 15'(month_term(ma)) + 15'(ya) + 15'(ya >> 2) + 15'(q >> 2) - 15'(q);
    return mod7(s);
  endfunction

endpackage

// File: hdl/cds_in_stage.sv
// ----------------------------------------------------------------------------
// cds_in_stage
// Input register: capture one request transaction and hold it until the
// date stage takes it.
// ----------------------------------------------------------------------------
module cds_in_stage import cds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cds_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cds_item_t item_o
);

  logic      valid_q;
  cds_item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// File: hdl/cds_date_core.sv
// ----------------------------------------------------------------------------
// cds_date_core
// Date register with load, one-day advance and one-day step back, including
// month and year carry and borrow and range checks.
// ----------------------------------------------------------------------------
module cds_date_core import cds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cds_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cds_date_t date_o
);

  logic              valid_q;
  logic              rej_q, rej_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic              leap_cur;
  logic              leap_load;
  logic [DayW-1:0]   len_cur;
  logic [DayW-1:0]   len_prev;
  logic [DayW-1:0]   len_load;

  assign leap_cur  = is_leap(year_q);
  assign leap_load = is_leap(item_i.year);
  assign len_cur   = month_len(month_q, leap_cur);
  assign len_prev  = month_len(month_q - MonthW'(1), leap_cur);
  assign len_load  = month_len(item_i.month, leap_load);

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    rej_d   = 1'b0;
    case (item_i.op)
      OP_LOAD: begin
        if (item_i.year < YearMin || item_i.year > YearMax ||
            item_i.month < MonthFirst || item_i.month > MonthLast ||
            item_i.day < DayFirst || item_i.day > len_load) begin
          rej_d = 1'b1;
        end else begin
          year_d  = item_i.year;
          month_d = item_i.month;
          day_d   = item_i.day;
        end
      end
      OP_NEXT: begin
        if (day_q < len_cur) begin
          day_d = day_q + DayW'(1);
        end else if (month_q < MonthLast) begin
          month_d = month_q + MonthW'(1);
          day_d   = DayFirst;
        end else if (year_q < YearMax) begin
          year_d  = year_q + YearW'(1);
          month_d = MonthFirst;
          day_d   = DayFirst;
        end else begin
          rej_d = 1'b1;
        end
      end
      OP_PREV: begin
        if (day_q > DayFirst) begin
          day_d = day_q - DayW'(1);
        end else if (month_q > MonthFirst) begin
          month_d = month_q - MonthW'(1);
          day_d   = len_prev;
        end else if (year_q > YearMin) begin
          year_d  = year_q - YearW'(1);
          month_d = MonthLast;
          day_d   = DayLast;
        end else begin
          rej_d = 1'b1;
        end
      end
      default: begin
        rej_d = 1'b1;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    date_o.rejected = rej_q;
    date_o.leap     = leap_cur;
    date_o.day      = day_q;
    date_o.month    = month_q;
    date_o.year     = year_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rej_q   <= 1'b0;
      year_q  <= ResetYear;
      month_q <= ResetMonth;
      day_q   <= ResetDay;
    end else if (ready_o) begin
      valid_q <= valid_i;
      if (valid_i) begin
        rej_q   <= rej_d;
        year_q  <= year_d;
        month_q <= month_d;
        day_q   <= day_d;
      end
    end
  end

endmodule

// File: hdl/cds_out_stage.sv
// ----------------------------------------------------------------------------
// cds_out_stage
// Weekday of the current date and the result register toward the output.
// ----------------------------------------------------------------------------
module cds_out_stage import cds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  cds_date_t   date_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] data_o
);

  logic        valid_q;
  logic [31:0] data_q, data_d;

  always_comb begin
    data_d = {4'b0, date_i.rejected, date_i.leap,
              weekday(date_i.year, date_i.month, date_i.day),
              date_i.day, date_i.month, date_i.year};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: hdl/calendar_day_stepper.sv
// ----------------------------------------------------------------------------
// calendar_day_stepper
// Gregorian date counter with load, next day and previous day requests;
// reports the date, leap flag, weekday and a reject flag per request.
//
//   channel  dir  tdata                                      tuser
//   s_axis   in   load_year, load_month, load_day (24 bits)  operation
//   m_axis   out  year, month, day, weekday, leap, rejected  -
//
// One transaction per cycle sustained while the output is not stalled; a request
// passes through the input register, the date register and the result register.
// The date register feeds back on itself, which sets the rate.
// Reset puts the date at 2021-01-01 and empties all stages.
// A stalled output holds its transaction; input is still taken while any
// stage is empty.
// ----------------------------------------------------------------------------
module calendar_day_stepper import cds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // load_year[13:0], load_month[17:14], load_day[22:18]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // year_now[13:0], month_now[17:14], day_now[22:18],
                                     // weekday[25:23], leap_year[26], rejected[27]
);

  cds_item_t in_item;
  cds_item_t s0_item;
  cds_date_t s1_date;
  logic      s0_valid, s0_ready;
  logic      s1_valid, s1_ready;

  always_comb begin
    in_item.op    = cds_op_e'(s_axis_tuser);
    in_item.year  = s_axis_tdata[13:0];
    in_item.month = s_axis_tdata[17:14];
    in_item.day   = s_axis_tdata[22:18];
  end

  cds_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (s0_valid),
    .ready_i (s0_ready),
    .item_o  (s0_item)
  );

  cds_date_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid),
    .ready_o (s0_ready),
    .item_i  (s0_item),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .date_o  (s1_date)
  );

  cds_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .date_i  (s1_date),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

// File: hdl/cds_checker.sv
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks for the calendar day stepper, bound to the top level.
// ----------------------------------------------------------------------------
module cds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input refused while output stage empty");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[17:14] != 4'd0 && m_axis_tdata[17:14] <= 4'd12 &&
                      m_axis_tdata[22:18] != 5'd0 && m_axis_tdata[25:23] != 3'd7 &&
                      m_axis_tdata[13:0] != 14'd0 && m_axis_tdata[31:28] == 4'd0)
    else $error("result date out of range");

  a_leap_div4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[1:0] == 2'b00)
    else $error("leap flag on a year not divisible by four");

endmodule

bind calendar_day_stepper cds_checker u_cds_checker (.*);

// File: tb/calendar_day_stepper_checker.sv
// ----------------------------------------------------------------------------
// calendar_day_stepper_checker
// Watches both stream channels of the calendar day stepper, tracks the date
// on its own, predicts the report for every accepted request and compares
// each returned report field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_day_stepper_checker import cds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,   // load_year[13:0], load_month[17:14], load_day[22:18]
  input  logic [1:0]  s_axis_tuser_i,   // operation[1:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // year_now[13:0], month_now[17:14], day_now[22:18],
                                        // weekday[25:23], leap_year[26], rejected[27]
  output int          mismatch_cnt_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [WdayW-1:0]  wday;
    logic              leap;
    logic              rejected;
  } day_report_t;

  day_report_t reports_q[$];
  day_report_t want;
  day_report_t got;
  int unsigned cal_year;
  int unsigned cal_month;
  int unsigned cal_day;

  function automatic bit leap_of(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(int unsigned y, int unsigned m);
    case (m)
      2:           return leap_of(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned weekday_of(int unsigned y, int unsigned m, int unsigned d);
    if (m < 3) begin
      m = m + 12;
      y = y - 1;
    end
    return (d + 2 * m + (3 * (m + 1)) / 5 + y + y / 4 - y / 100 + y / 400) % 7;
  endfunction

  function automatic day_report_t apply_request(cds_op_e op, int unsigned ly,
                                                int unsigned lm, int unsigned ld);
    bit          rej;
    day_report_t rep;
    rej = 1'b0;
    case (op)
      OP_LOAD: begin
        if (ly < YearMin || ly > YearMax || lm < MonthFirst || lm > MonthLast ||
            ld < DayFirst || ld > days_in(ly, lm)) begin
          rej = 1'b1;
        end else begin
          cal_year  = ly;
          cal_month = lm;
          cal_day   = ld;
        end
      end
      OP_NEXT: begin
        if (cal_day < days_in(cal_year, cal_month)) begin
          cal_day = cal_day + 1;
        end else if (cal_month < MonthLast) begin
          cal_month = cal_month + 1;
          cal_day   = 1;
        end else if (cal_year < YearMax) begin
          cal_year  = cal_year + 1;
          cal_month = 1;
          cal_day   = 1;
        end else begin
          rej = 1'b1;
        end
      end
      OP_PREV: begin
        if (cal_day > 1) begin
          cal_day = cal_day - 1;
        end else if (cal_month > 1) begin
          cal_month = cal_month - 1;
          cal_day   = days_in(cal_year, cal_month);
        end else if (cal_year > YearMin) begin
          cal_year  = cal_year - 1;
          cal_month = 12;
          cal_day   = 31;
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase
    rep.year     = YearW'(cal_year);
    rep.month    = MonthW'(cal_month);
    rep.day      = DayW'(cal_day);
    rep.wday     = WdayW'(weekday_of(cal_year, cal_month, cal_day));
    rep.leap     = leap_of(cal_year);
    rep.rejected = rej;
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_cnt_o = mismatch_cnt_o + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_year       = 32'(ResetYear);
      cal_month      = 32'(ResetMonth);
      cal_day        = 32'(ResetDay);
      mismatch_cnt_o = 0;
      reports_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.year     = m_axis_tdata_i[13:0];
        got.month    = m_axis_tdata_i[17:14];
        got.day      = m_axis_tdata_i[22:18];
        got.wday     = m_axis_tdata_i[25:23];
        got.leap     = m_axis_tdata_i[26];
        got.rejected = m_axis_tdata_i[27];
        if (reports_q.size() == 0) begin
          $error("unexpected result transaction: year %0d month %0d day %0d",
                 got.year, got.month, got.day);
          mismatch_cnt_o = mismatch_cnt_o + 1;
        end else begin
          want = reports_q.pop_front();
          check_field("year_now", 32'(want.year), 32'(got.year));
          check_field("month_now", 32'(want.month), 32'(got.month));
          check_field("day_now", 32'(want.day), 32'(got.day));
          check_field("weekday", 32'(want.wday), 32'(got.wday));
          check_field("leap_year", 32'(want.leap), 32'(got.leap));
          check_field("rejected", 32'(want.rejected), 32'(got.rejected));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        reports_q.insert(reports_q.size(),
                         apply_request(cds_op_e'(s_axis_tuser_i), 32'(s_axis_tdata_i[13:0]),
                                       32'(s_axis_tdata_i[17:14]),
                                       32'(s_axis_tdata_i[22:18])));
      end
    end
    outstanding_o = reports_q.size();
  end

endmodule

// File: tb/calendar_day_stepper_tb.sv
// ----------------------------------------------------------------------------
// calendar_day_stepper_tb
// Drives load, next day and previous day requests into the calendar day
// stepper: a directed pass over year, month and leap boundaries and invalid
// loads, then random runs of steps mixed with loads under varying idle and
// backpressure; the checker predicts and compares every report.
// ----------------------------------------------------------------------------
module calendar_day_stepper_tb import cds_pkg::*; ();

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 388;
  localparam int TailCycles  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // load_year[13:0], load_month[17:14], load_day[22:18]
  logic [1:0]  s_axis_tuser;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // year_now[13:0], month_now[17:14], day_now[22:18],
                               // weekday[25:23], leap_year[26], rejected[27]
  int          mismatch_cnt;
  int          outstanding;
  int          idle_pct;
  int          stall_pct;
  int          cycle_cnt = 0;

  calendar_day_stepper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  calendar_day_stepper_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .mismatch_cnt_o  (mismatch_cnt),
    .outstanding_o   (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(cds_op_e op, logic [YearW-1:0] y, logic [MonthW-1:0] m,
                           logic [DayW-1:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, d, m, y};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_step(cds_op_e op);
    send_item(op, YearW'($urandom), MonthW'($urandom), DayW'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic random_item(ref bit fwd);
    int               r;
    logic [YearW-1:0] y;
    logic [MonthW-1:0] m;
    logic [DayW-1:0]  d;
    r = $urandom_range(99);
    if ($urandom_range(99) < 12) begin
      fwd = !fwd;
    end
    if (r < 70) begin
      send_step(fwd ? OP_NEXT : OP_PREV);
    end else if (r < 86) begin
      case ($urandom_range(5))
        0:       y = YearW'($urandom_range(1, 2));
        1:       y = YearW'($urandom_range(9998, 9999));
        2:       y = YearW'(100 * $urandom_range(15, 24));
        default: y = YearW'($urandom_range(1, 9999));
      endcase
      m = MonthW'($urandom_range(1, 12));
      d = ($urandom_range(1)) ? DayW'($urandom_range(1, 28)) : DayW'($urandom_range(28, 31));
      send_item(OP_LOAD, y, m, d);
    end else if (r < 95) begin
      send_item(OP_LOAD, YearW'($urandom), MonthW'($urandom), DayW'($urandom));
    end else begin
      send_step(OP_NONE);
    end
  endtask

  initial begin
    bit fwd;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    idle_pct      = 0;
    stall_pct     = 0;
    fwd           = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_step(OP_NEXT);
    send_step(OP_PREV);
    send_step(OP_PREV);
    send_item(OP_LOAD, YearW'(9999), MonthW'(12), DayW'(31));
    send_step(OP_NEXT);
    send_step(OP_PREV);
    send_step(OP_NEXT);
    send_item(OP_LOAD, YearW'(1), MonthW'(1), DayW'(1));
    send_step(OP_PREV);
    send_step(OP_NEXT);
    send_item(OP_LOAD, YearW'(0), MonthW'(5), DayW'(5));
    send_item(OP_LOAD, YearW'(16383), MonthW'(15), DayW'(31));
    send_item(OP_LOAD, YearW'(2000), MonthW'(0), DayW'(10));
    send_item(OP_LOAD, YearW'(2000), MonthW'(13), DayW'(10));
    send_item(OP_LOAD, YearW'(2000), MonthW'(4), DayW'(0));
    send_item(OP_LOAD, YearW'(2000), MonthW'(4), DayW'(31));
    send_item(OP_LOAD, YearW'(2000), MonthW'(2), DayW'(29));
    send_item(OP_LOAD, YearW'(1900), MonthW'(2), DayW'(29));
    send_item(OP_LOAD, YearW'(2024), MonthW'(2), DayW'(29));
    send_step(OP_NEXT);
    send_step(OP_PREV);
    send_step(OP_NONE);
    send_item(OP_LOAD, YearW'(2100), MonthW'(12), DayW'(31));
    send_step(OP_NEXT);
    send_item(OP_LOAD, YearW'(2023), MonthW'(3), DayW'(1));
    send_step(OP_PREV);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 50; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        random_item(fwd);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
